@@ rtl/dfd_pkg.sv @@
// Shared types, constants and checksum helper for the link frame deframer.
package dfd_pkg;

  localparam logic [7:0] SyncA = 8'ha3;
  localparam logic [7:0] SyncB = 8'hb2;
  localparam logic [7:0] SyncC = 8'hc1;

  localparam int HdrLen    = 20;
  localparam int HdrSumLen = 12;
  localparam int PoseLen   = 56;
  localparam int PoseWords = 9;
  localparam int PoseBytes = 4 * PoseWords;
  localparam int QDepth    = 2;

  localparam logic [30:0] TargetIdReset = 31'd230;
  localparam logic [15:0] SumInit       = 16'hffff;

  typedef enum logic [1:0] {
    StPose   = 2'd0,
    StHdrBad = 2'd1,
    StSumBad = 2'd2,
    StOther  = 2'd3
  } status_e;

  typedef struct packed {
    status_e                       status;
    logic [31:0]                   msg_id;
    logic [9:0]                    msg_size;
    logic [PoseWords-1:0][31:0]    pose;
  } rec_t;

  // Ones'-complement 16-bit add with end-around carry.
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'b0, s[16]};
  endfunction

endpackage

@@ rtl/dfd_front.sv @@
// Byte parser: sync hunt, header capture, running sums and frame judgement.
module dfd_front #(
  parameter int MAX_FRAME = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          rx_byte_i,
  input  logic [30:0]         target_id_i,
  output logic                push_o,
  output dfd_pkg::rec_t       push_rec_o
);

  localparam int CW = $clog2(MAX_FRAME);

  localparam logic [1:0] PhHunt    = 2'd0;
  localparam logic [1:0] PhHeader  = 2'd1;
  localparam logic [1:0] PhPayload = 2'd2;

  localparam logic [15:0] SyncLow  = dfd_pkg::oc_add(dfd_pkg::SumInit,
                                                     {dfd_pkg::SyncB, dfd_pkg::SyncA});
  localparam logic [15:0] SyncHigh = dfd_pkg::oc_add(dfd_pkg::SumInit, SyncLow);

  logic [1:0]    phase_q, phase_d;
  logic [15:0]   hist_q, hist_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [31:0]   id_q, id_d;
  logic [31:0]   size_q, size_d;
  logic [31:0]   hchk_q, hchk_d;
  logic [31:0]   bchk_q, bchk_d;
  logic [15:0]   low_q, low_d;
  logic [15:0]   high_q, high_d;
  logic [7:0]    pend_q, pend_d;
  logic [dfd_pkg::PoseWords-1:0][31:0] pay_q, pay_d;

  logic [4:0]    hc;
  logic [CW-1:0] pc;
  logic [CW-1:0] cnt_inc;
  logic          odd;
  logic [15:0]   add_word;
  logic [15:0]   add_low;
  logic [15:0]   add_high;
  logic [31:0]   fin_sum;
  logic [31:0]   fin_chk;
  logic          finish;
  logic          hdr_ok;

  assign hc       = cnt_q[4:0];
  assign pc       = cnt_q - CW'(dfd_pkg::HdrLen);
  assign cnt_inc  = cnt_q + CW'(1);
  assign odd      = (phase_q == PhHeader) ? hc[0] : pc[0];
  assign add_word = odd ? {rx_byte_i, pend_q} : {8'h00, rx_byte_i};
  assign add_low  = dfd_pkg::oc_add(low_q, add_word);
  assign add_high = dfd_pkg::oc_add(high_q, add_low);

  always_comb begin
    phase_d    = phase_q;
    hist_d     = hist_q;
    cnt_d      = cnt_q;
    id_d       = id_q;
    size_d     = size_q;
    hchk_d     = hchk_q;
    bchk_d     = bchk_q;
    low_d      = low_q;
    high_d     = high_q;
    pend_d     = pend_q;
    pay_d      = pay_q;
    finish     = 1'b0;
    fin_sum    = 32'hffff_ffff;
    fin_chk    = bchk_q;
    hdr_ok     = 1'b1;
    push_o     = 1'b0;
    push_rec_o = '0;

    if (fire_i) begin
      unique case (phase_q)
        PhHeader: begin
          if (hc < 5'(dfd_pkg::HdrSumLen)) begin
            if (hc[0]) begin
              low_d  = add_low;
              high_d = add_high;
            end else begin
              pend_d = rx_byte_i;
            end
          end
          unique case (hc[4:2])
            3'd1:    id_d[8*hc[1:0] +: 8]   = rx_byte_i;
            3'd2:    size_d[8*hc[1:0] +: 8] = rx_byte_i;
            3'd3:    hchk_d[8*hc[1:0] +: 8] = rx_byte_i;
            3'd4:    bchk_d[8*hc[1:0] +: 8] = rx_byte_i;
            default: ;
          endcase
          cnt_d = cnt_inc;
          if (hc == 5'(dfd_pkg::HdrLen - 1)) begin
            hdr_ok = ({high_q, low_q} == hchk_q) &&
                     (size_q >= 32'(dfd_pkg::HdrLen)) &&
                     (size_q <= 32'(MAX_FRAME - 1));
            if (!hdr_ok) begin
              push_o            = 1'b1;
              push_rec_o.status = dfd_pkg::StHdrBad;
              phase_d           = PhHunt;
              cnt_d             = '0;
              hist_d            = '0;
            end else begin
              low_d   = dfd_pkg::SumInit;
              high_d  = dfd_pkg::SumInit;
              pend_d  = '0;
              phase_d = PhPayload;
              // A header-only frame is judged right away against the empty sum.
              if (size_q == 32'(dfd_pkg::HdrLen)) begin
                finish  = 1'b1;
                fin_sum = 32'hffff_ffff;
                fin_chk = {rx_byte_i, bchk_q[23:0]};
              end
            end
          end
        end
        PhPayload: begin
          if (pc[0]) begin
            low_d  = add_low;
            high_d = add_high;
          end else begin
            pend_d = rx_byte_i;
          end
          if (pc < CW'(dfd_pkg::PoseBytes)) begin
            pay_d[pc[5:2]][8*pc[1:0] +: 8] = rx_byte_i;
          end
          cnt_d = cnt_inc;
          if (cnt_inc >= size_q[CW-1:0]) begin
            // The final word is folded in here, odd trailing byte included.
            finish  = 1'b1;
            fin_sum = {add_high, add_low};
            fin_chk = bchk_q;
          end
        end
        default: begin
          if (hist_q == {dfd_pkg::SyncA, dfd_pkg::SyncB} && rx_byte_i == dfd_pkg::SyncC) begin
            low_d   = SyncLow;
            high_d  = SyncHigh;
            pend_d  = dfd_pkg::SyncC;
            id_d    = '0;
            size_d  = '0;
            hchk_d  = '0;
            bchk_d  = '0;
            cnt_d   = CW'(3);
            hist_d  = '0;
            phase_d = PhHeader;
          end else begin
            phase_d = PhHunt;
            hist_d  = {hist_q[7:0], rx_byte_i};
          end
        end
      endcase

      if (finish) begin
        push_o              = 1'b1;
        push_rec_o.msg_id   = id_q;
        push_rec_o.msg_size = size_q[9:0];
        push_rec_o.pose     = pay_d;
        if (fin_sum != fin_chk) begin
          push_rec_o.status = dfd_pkg::StSumBad;
        end else if (id_q == {1'b0, target_id_i} && size_q == 32'(dfd_pkg::PoseLen)) begin
          push_rec_o.status = dfd_pkg::StPose;
        end else begin
          push_rec_o.status = dfd_pkg::StOther;
        end
        phase_d = PhHunt;
        cnt_d   = '0;
        hist_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      hist_q  <= '0;
      cnt_q   <= '0;
      id_q    <= '0;
      size_q  <= '0;
      hchk_q  <= '0;
      bchk_q  <= '0;
      low_q   <= dfd_pkg::SumInit;
      high_q  <= dfd_pkg::SumInit;
      pend_q  <= '0;
    end else begin
      phase_q <= phase_d;
      hist_q  <= hist_d;
      cnt_q   <= cnt_d;
      id_q    <= id_d;
      size_q  <= size_d;
      hchk_q  <= hchk_d;
      bchk_q  <= bchk_d;
      low_q   <= low_d;
      high_q  <= high_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q <= pay_d;
  end

endmodule

@@ rtl/dfd_queue.sv @@
// Short result queue between the byte parser and the output stage.
module dfd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dfd_pkg::rec_t push_rec_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output dfd_pkg::rec_t rec_o
);

  localparam int PW = (dfd_pkg::QDepth > 1) ? $clog2(dfd_pkg::QDepth) : 1;
  localparam int NW = $clog2(dfd_pkg::QDepth + 1);

  dfd_pkg::rec_t mem_q [dfd_pkg::QDepth];
  logic [PW-1:0] wr_q, wr_d;
  logic [PW-1:0] rd_q, rd_d;
  logic [NW-1:0] num_q, num_d;
  logic          do_push;
  logic          do_pop;

  assign full_o  = (num_q == NW'(dfd_pkg::QDepth));
  assign valid_o = (num_q != '0);
  assign rec_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    num_d = num_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(dfd_pkg::QDepth - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(dfd_pkg::QDepth - 1)) ? '0 : rd_q + PW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   num_d = num_q + NW'(1);
      2'b01:   num_d = num_q - NW'(1);
      default: num_d = num_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      num_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      num_q <= num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_rec_i;
    end
  end

endmodule

@@ rtl/dfd_back.sv @@
// Output stage: formats pose fields and holds the result beat for the receiver.
module dfd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  dfd_pkg::rec_t      q_rec_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] message_id_o,
  output logic [9:0]         message_size_o,
  output logic [31:0]        pos_x_bits_o,
  output logic [31:0]        pos_y_bits_o,
  output logic [31:0]        pos_down_bits_o,
  output logic [31:0]        quat_x_bits_o,
  output logic [31:0]        quat_y_bits_o,
  output logic [31:0]        quat_z_bits_o,
  output logic [31:0]        quat_w_bits_o,
  output logic signed [31:0] frame_number_o,
  output logic signed [31:0] valid_word_o
);

  logic                                valid_q;
  dfd_pkg::status_e                    status_q;
  logic [31:0]                         id_q;
  logic [9:0]                          size_q;
  logic [dfd_pkg::PoseWords-1:0][31:0] pose_q, pose_d;
  logic                                load;

  assign load    = q_valid_i && (!valid_q || out_ready_i);
  assign q_pop_o = load;

  always_comb begin
    pose_d = '0;
    if (q_rec_i.status == dfd_pkg::StPose) begin
      pose_d    = q_rec_i.pose;
      // Down axis is the z word with its sign flipped.
      pose_d[2] = q_rec_i.pose[2] ^ 32'h8000_0000;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q <= q_rec_i.status;
      id_q     <= q_rec_i.msg_id;
      size_q   <= q_rec_i.msg_size;
      pose_q   <= pose_d;
    end
  end

  assign out_valid_o     = valid_q;
  assign status_o        = status_q;
  assign message_id_o    = id_q;
  assign message_size_o  = size_q;
  assign pos_x_bits_o    = pose_q[0];
  assign pos_y_bits_o    = pose_q[1];
  assign pos_down_bits_o = pose_q[2];
  assign quat_x_bits_o   = pose_q[3];
  assign quat_y_bits_o   = pose_q[4];
  assign quat_z_bits_o   = pose_q[5];
  assign quat_w_bits_o   = pose_q[6];
  assign frame_number_o  = pose_q[7];
  assign valid_word_o    = pose_q[8];

endmodule

@@ rtl/datalink_frame_deframer.sv @@
// Top level of the link frame deframer: config register, parser, queue, output stage.
//
// Bytes enter on the in channel (in_valid_i / in_ready_o / rx_byte_i), one beat
// per cycle while ready. The parser hunts for the sync triple A3 B2 C1, takes
// a 20-byte header, checks its Fletcher-32 style sum and the size, then runs the
// payload sum. Each judged frame yields one result beat on the out channel
// (out_valid_o / out_ready_i) carrying status, id, size and, for a 56-byte frame
// of the target id, the nine pose words.
// Throughput is one byte per cycle while the queue has room; the per-byte work is
// one pair of 16-bit end-around adds in the parser. A result is written into the
// queue with the byte that completes the frame and moves on into the output
// register once that register is free.
// When the receiver stalls, results collect in the two-entry queue behind the
// held output beat; in_ready_o drops only when the queue is full.
// Reset clears the parser to hunting, empties the queue and output stage and
// sets the target id to 230. cfg_we_i writes the target id from cfg_wdata_i.
module datalink_frame_deframer #(
  parameter int MAX_FRAME = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [30:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] message_id_o,
  output logic [9:0]         message_size_o,
  output logic [31:0]        pos_x_bits_o,
  output logic [31:0]        pos_y_bits_o,
  output logic [31:0]        pos_down_bits_o,
  output logic [31:0]        quat_x_bits_o,
  output logic [31:0]        quat_y_bits_o,
  output logic [31:0]        quat_z_bits_o,
  output logic [31:0]        quat_w_bits_o,
  output logic signed [31:0] frame_number_o,
  output logic signed [31:0] valid_word_o
);

  logic [30:0]   target_q;
  logic          fire;
  logic          push;
  dfd_pkg::rec_t push_rec;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  dfd_pkg::rec_t q_rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= dfd_pkg::TargetIdReset;
    end else if (cfg_we_i) begin
      target_q <= cfg_wdata_i;
    end
  end

  assign in_ready_o = !q_full;
  assign fire       = in_valid_i && in_ready_o;

  dfd_front #(
    .MAX_FRAME(MAX_FRAME)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .rx_byte_i  (rx_byte_i),
    .target_id_i(target_q),
    .push_o     (push),
    .push_rec_o (push_rec)
  );

  dfd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_rec_i(push_rec),
    .pop_i     (q_pop),
    .full_o    (q_full),
    .valid_o   (q_valid),
    .rec_o     (q_rec)
  );

  dfd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_rec_i        (q_rec),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .message_id_o   (message_id_o),
    .message_size_o (message_size_o),
    .pos_x_bits_o   (pos_x_bits_o),
    .pos_y_bits_o   (pos_y_bits_o),
    .pos_down_bits_o(pos_down_bits_o),
    .quat_x_bits_o  (quat_x_bits_o),
    .quat_y_bits_o  (quat_y_bits_o),
    .quat_z_bits_o  (quat_z_bits_o),
    .quat_w_bits_o  (quat_w_bits_o),
    .frame_number_o (frame_number_o),
    .valid_word_o   (valid_word_o)
  );

endmodule

@@ rtl/dfd_checker.sv @@
// Port-level checker for the link frame deframer, bound to the top level.
module dfd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic [30:0]        cfg_wdata_i,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [7:0]         rx_byte_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [1:0]         status_o,
  input logic signed [31:0] message_id_o,
  input logic [9:0]         message_size_o,
  input logic [31:0]        pos_x_bits_o,
  input logic [31:0]        pos_y_bits_o,
  input logic [31:0]        pos_down_bits_o,
  input logic [31:0]        quat_x_bits_o,
  input logic [31:0]        quat_y_bits_o,
  input logic [31:0]        quat_z_bits_o,
  input logic [31:0]        quat_w_bits_o,
  input logic signed [31:0] frame_number_o,
  input logic signed [31:0] valid_word_o
);

  logic pose_zero;

  assign pose_zero = (pos_x_bits_o == '0) && (pos_y_bits_o == '0) &&
                     (pos_down_bits_o == '0) && (quat_x_bits_o == '0) &&
                     (quat_y_bits_o == '0) && (quat_z_bits_o == '0) &&
                     (quat_w_bits_o == '0) && (frame_number_o == '0) &&
                     (valid_word_o == '0);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // Pose words show only on an accepted pose frame.
  a_pose_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != dfd_pkg::StPose |-> pose_zero)
    else $error("pose words nonzero on a non-pose result");

  // A rejected header reports neither id nor size.
  a_hdr_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == dfd_pkg::StHdrBad |->
      message_id_o == '0 && message_size_o == '0)
    else $error("rejected header shows id or size");

  // A pose frame is always the fixed pose length.
  a_pose_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == dfd_pkg::StPose |->
      message_size_o == 10'(dfd_pkg::PoseLen))
    else $error("pose result with wrong size");

endmodule

bind datalink_frame_deframer dfd_checker u_dfd_checker (.*);
